### rtl/matrix3_inverse_macros.svh
// ============================================================================
// matrix3_inverse_macros.svh
// Assertion macros shared by the matrix inverse RTL. Each macro is sampled on
// the rising edge of clk and switched off while rst_n is low.
// ============================================================================
`ifndef MATRIX3_INVERSE_MACROS_SVH
`define MATRIX3_INVERSE_MACROS_SVH
`ifndef ASSERT_OFF
// check that a property holds
`define M3I_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that an expression never becomes true
`define M3I_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define M3I_ASSERT(lbl, prop, msg)
`define M3I_NEVER(lbl, expr, msg)
`endif
`endif

### rtl/m3i_pkg.sv
// ============================================================================
// m3i_pkg
// Types, widths and tables shared by the 3x3 matrix inverse pipeline.
// ============================================================================
package m3i_pkg;

    localparam int ELEM_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int NUM_EL     = 9;
    localparam int IDX_W      = 4;

    localparam int PROD_W = 2 * ELEM_WIDTH;              // element x element
    localparam int COF_W  = PROD_W + 1;                  // cofactor difference
    localparam int HI_W   = COF_W - ELEM_WIDTH;          // upper slice of a cofactor
    localparam int PP_W   = ELEM_WIDTH + HI_W;           // partial product for det
    localparam int DET_W  = ELEM_WIDTH + COF_W + 2;      // sum of three products
    localparam int DMAG_W = DET_W;                       // determinant magnitude
    localparam int NUM_W  = COF_W + 2 * FRAC_BITS;       // dividend magnitude
    localparam int QUO_W  = ELEM_WIDTH + 1;              // quotient bits kept
    localparam int WIDE_W = DMAG_W + QUO_W;              // divider compare width

    localparam int ADJ_LAT   = 2;
    localparam int DET_LAT   = 4;
    localparam int DIV_LAT   = 2 + QUO_W;
    localparam int TOTAL_LAT = ADJ_LAT + DET_LAT + DIV_LAT + 1;

    typedef logic signed [ELEM_WIDTH-1:0] elem_t;
    typedef logic signed [COF_W-1:0]      cof_t;
    typedef logic signed [DET_W-1:0]      det_t;
    typedef logic [IDX_W-1:0]             idx_t;
    typedef cof_t                         cof_vec_t [NUM_EL];

    localparam elem_t SAT_MAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
    localparam elem_t SAT_MIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

    // element indexes (row order) for each cofactor: p*q - r*s
    localparam idx_t COF_IDX [NUM_EL][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    typedef struct packed {
        elem_t a11; elem_t a12; elem_t a13;
        elem_t a21; elem_t a22; elem_t a23;
        elem_t a31; elem_t a32; elem_t a33;
    } matrix_t;

    typedef struct packed {
        elem_t r11; elem_t r12; elem_t r13;
        elem_t r21; elem_t r22; elem_t r23;
        elem_t r31; elem_t r32; elem_t r33;
        logic  singular;
    } result_t;

    typedef struct packed {
        logic [DMAG_W-1:0] dmag;
        logic              dneg;
        logic              singular;
    } det_info_t;

endpackage

### rtl/m3i_adj.sv
// ============================================================================
// m3i_adj
// Adjugate stages: eighteen element products, then the nine differences.
// ============================================================================
module m3i_adj import m3i_pkg::*;
(
    input  logic     clk,
    input  matrix_t  matrix,
    output cof_vec_t adj,
    output elem_t    col [3]
);

    elem_t el [NUM_EL];
    logic signed [PROD_W-1:0] pa_reg [NUM_EL];
    logic signed [PROD_W-1:0] pb_reg [NUM_EL];
    cof_vec_t adj_reg;
    elem_t    col1_reg [3];
    elem_t    col2_reg [3];

    assign el[0] = matrix.a11;
    assign el[1] = matrix.a12;
    assign el[2] = matrix.a13;
    assign el[3] = matrix.a21;
    assign el[4] = matrix.a22;
    assign el[5] = matrix.a23;
    assign el[6] = matrix.a31;
    assign el[7] = matrix.a32;
    assign el[8] = matrix.a33;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_EL; i++)
        begin
            pa_reg[i]  <= el[COF_IDX[i][0]] * el[COF_IDX[i][1]];
            pb_reg[i]  <= el[COF_IDX[i][2]] * el[COF_IDX[i][3]];
            adj_reg[i] <= $signed({pa_reg[i][PROD_W-1], pa_reg[i]})
                        - $signed({pb_reg[i][PROD_W-1], pb_reg[i]});
        end
        // first column feeds the determinant expansion
        for (int j = 0; j < 3; j++)
        begin
            col1_reg[j] <= el[3*j];
            col2_reg[j] <= col1_reg[j];
        end
    end

    assign adj = adj_reg;
    assign col = col2_reg;

endmodule

### rtl/m3i_det.sv
// ============================================================================
// m3i_det
// Determinant stages: split products, term assembly, sum, magnitude, sign and zero test.
// Delays the adjugate to stay aligned with the determinant.
// ============================================================================
module m3i_det import m3i_pkg::*;
(
    input  logic      clk,
    input  cof_vec_t  adj_in,
    input  elem_t     col [3],
    output cof_vec_t  adj_out,
    output det_info_t info
);

    logic signed [PP_W-1:0] plo_reg [3];
    logic signed [PP_W-1:0] phi_reg [3];
    det_t      term_reg [3];
    det_t      det_reg;
    det_info_t info_reg;
    cof_vec_t  adj_d_reg [DET_LAT];

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            plo_reg[j]  <= col[j] * $signed({1'b0, adj_in[j][ELEM_WIDTH-1:0]});
            phi_reg[j]  <= col[j] * $signed(adj_in[j][COF_W-1:ELEM_WIDTH]);
            term_reg[j] <= (det_t'(phi_reg[j]) <<< ELEM_WIDTH) + det_t'(plo_reg[j]);
        end
        det_reg <= term_reg[0] + term_reg[1] + term_reg[2];
        info_reg.dmag     <= det_reg[DET_W-1] ? DMAG_W'(-det_reg) : DMAG_W'(det_reg);
        info_reg.dneg     <= det_reg[DET_W-1];
        info_reg.singular <= (det_reg == '0);

        adj_d_reg[0] <= adj_in;
        for (int k = 1; k < DET_LAT; k++)
        begin
            adj_d_reg[k] <= adj_d_reg[k-1];
        end
    end

    assign adj_out = adj_d_reg[DET_LAT-1];
    assign info    = info_reg;

endmodule

### rtl/m3i_div.sv
// ============================================================================
// m3i_div
// Pipelined restoring divider for one inverse element: one quotient bit per
// stage, overflow detected up front, saturating output.
// ============================================================================
module m3i_div import m3i_pkg::*;
(
    input  logic              clk,
    input  cof_t              adj,
    input  logic [DMAG_W-1:0] dmag,
    input  logic              dneg,
    output elem_t             quot
);

    logic [NUM_W-1:0]  numa_reg;
    logic              nega_reg;
    logic [DMAG_W-1:0] dmaga_reg;
    logic [COF_W-1:0]  adj_mag;

    logic [NUM_W-1:0]  rem_reg  [QUO_W+1];
    logic [QUO_W-1:0]  q_reg    [QUO_W+1];
    logic [DMAG_W-1:0] dmag_reg [QUO_W+1];
    logic              neg_reg  [QUO_W+1];
    logic              ovf_reg  [QUO_W+1];

    logic [QUO_W-1:0]  q_fin;
    logic              big_q;

    assign adj_mag = adj[COF_W-1] ? COF_W'(-adj) : COF_W'(adj);

    // stage A: dividend magnitude and result sign
    always_ff @(posedge clk)
    begin
        numa_reg  <= {adj_mag, {(2*FRAC_BITS){1'b0}}};
        nega_reg  <= adj[COF_W-1] ^ dneg;
        dmaga_reg <= dmag;
    end

    // stage B: quotient too large for the kept bits
    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= numa_reg;
        q_reg[0]    <= '0;
        dmag_reg[0] <= dmaga_reg;
        neg_reg[0]  <= nega_reg;
        ovf_reg[0]  <= {{(WIDE_W-NUM_W){1'b0}}, numa_reg} >= {dmaga_reg, {QUO_W{1'b0}}};
    end

    for (genvar s = 0; s < QUO_W; s++)
    begin : g_step
        logic [WIDE_W:0]   trial;
        logic [WIDE_W-1:0] dsh;
        logic [QUO_W-1:0]  q_next;

        assign dsh   = {dmag_reg[s], {QUO_W{1'b0}}} >> (s + 1);
        assign trial = {{(WIDE_W-NUM_W+1){1'b0}}, rem_reg[s]} - {1'b0, dsh};

        always_comb
        begin
            q_next = q_reg[s];
            q_next[QUO_W-1-s] = !trial[WIDE_W];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s+1]  <= trial[WIDE_W] ? rem_reg[s] : trial[NUM_W-1:0];
            q_reg[s+1]    <= q_next;
            dmag_reg[s+1] <= dmag_reg[s];
            neg_reg[s+1]  <= neg_reg[s];
            ovf_reg[s+1]  <= ovf_reg[s];
        end
    end

    // saturate: positive clips at max, negative may reach exactly min
    assign q_fin = q_reg[QUO_W];
    assign big_q = q_fin[QUO_W-1] | q_fin[QUO_W-2];

    always_comb
    begin
        if (!neg_reg[QUO_W])
        begin
            quot = (ovf_reg[QUO_W] || big_q) ? SAT_MAX : elem_t'(q_fin[ELEM_WIDTH-1:0]);
        end
        else if (ovf_reg[QUO_W] || q_fin[QUO_W-1]
                 || (q_fin[QUO_W-2] && (q_fin[QUO_W-3:0] != '0)))
        begin
            quot = SAT_MIN;
        end
        else
        begin
            quot = elem_t'(-q_fin[ELEM_WIDTH-1:0]);
        end
    end

endmodule

### rtl/matrix3_inverse.sv
// ============================================================================
// matrix3_inverse
// 3x3 Q16.16 matrix inverse by adjugate over determinant, fully pipelined.
// ============================================================================
// Throughput: one matrix per cycle; busy stays low, the pipe never stalls.
// 33 stages of the restoring divider, one quotient bit each, make up most of the pipe depth.
// Reset clears the valid and singular pipes only; data registers free-run.
// The receiver cannot stall: each result shows for exactly one cycle.
`include "matrix3_inverse_macros.svh"

module matrix3_inverse import m3i_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  matrix_t matrix,
    output logic    done,
    output result_t result
);

    cof_vec_t  adj_s2;
    elem_t     col_s2 [3];
    cof_vec_t  adj_s6;
    det_info_t info_s6;
    elem_t     quot [NUM_EL];

    // valid travels next to the data; singular joins after the determinant
    logic    vld_reg  [TOTAL_LAT];
    logic    sing_reg [DIV_LAT];
    result_t result_reg;
    result_t result_next;

    // the pipe takes an item in every cycle
    assign busy = 1'b0;

    // stages 1-2: cofactor products and differences
    m3i_adj u_adj
    (
        .clk    (clk),
        .matrix (matrix),
        .adj    (adj_s2),
        .col    (col_s2)
    );

    // stages 3-6: determinant, its magnitude, sign and zero test
    m3i_det u_det
    (
        .clk     (clk),
        .adj_in  (adj_s2),
        .col     (col_s2),
        .adj_out (adj_s6),
        .info    (info_s6)
    );

    // stages 7-41: one divider per inverse element
    for (genvar i = 0; i < NUM_EL; i++)
    begin : g_div
        m3i_div u_div
        (
            .clk  (clk),
            .adj  (adj_s6[i]),
            .dmag (info_s6.dmag),
            .dneg (info_s6.dneg),
            .quot (quot[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TOTAL_LAT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            for (int k = 0; k < DIV_LAT; k++)
            begin
                sing_reg[k] <= 1'b0;
            end
        end
        else
        begin
            // advance the valid bits every cycle
            vld_reg[0] <= start && !busy;
            for (int k = 1; k < TOTAL_LAT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
            // hold the singular flag alongside the dividers
            sing_reg[0] <= info_s6.singular;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                sing_reg[k] <= sing_reg[k-1];
            end
        end
    end

    // drop the quotients to zero for a singular matrix
    always_comb
    begin
        result_next.r11      = sing_reg[DIV_LAT-1] ? '0 : quot[0];
        result_next.r12      = sing_reg[DIV_LAT-1] ? '0 : quot[1];
        result_next.r13      = sing_reg[DIV_LAT-1] ? '0 : quot[2];
        result_next.r21      = sing_reg[DIV_LAT-1] ? '0 : quot[3];
        result_next.r22      = sing_reg[DIV_LAT-1] ? '0 : quot[4];
        result_next.r23      = sing_reg[DIV_LAT-1] ? '0 : quot[5];
        result_next.r31      = sing_reg[DIV_LAT-1] ? '0 : quot[6];
        result_next.r32      = sing_reg[DIV_LAT-1] ? '0 : quot[7];
        result_next.r33      = sing_reg[DIV_LAT-1] ? '0 : quot[8];
        result_next.singular = sing_reg[DIV_LAT-1];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = vld_reg[TOTAL_LAT-1];
    assign result = result_reg;

    `M3I_ASSERT(a_done_follows_start, start && !busy |-> ##TOTAL_LAT done, "item lost in pipe")
    `M3I_ASSERT(a_done_has_start, done |-> $past(start && !busy, TOTAL_LAT), "result without item")
    `M3I_NEVER(a_singular_zero,
        done && result.singular && (result[$bits(result_t)-1:1] != '0),
        "singular result not zero")

endmodule

### sim/matrix3_inverse_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3_inverse_checker
// Watches the matrix and result channels of the inverse block, predicts each
// inverse with exact wide arithmetic and compares it with what comes out.
// ----------------------------------------------------------------------------
module matrix3_inverse_checker import m3i_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    busy,
    input  matrix_t matrix,
    input  logic    done,
    input  result_t result,
    output int      fail_count,
    output int      pending
);

    typedef logic signed [191:0] wide_t;

    result_t inverse_q[$];

    function automatic elem_t divide_sat(wide_t cof, wide_t det);
        wide_t num;
        wide_t q;
        wide_t lim;
        num = cof <<< (2 * FRAC_BITS);
        q   = num / det;                    // truncates toward zero
        lim = wide_t'(1) <<< (ELEM_WIDTH - 1);
        if (q >= lim)
            return SAT_MAX;
        if (q < -lim)
            return SAT_MIN;
        return elem_t'(q);
    endfunction

    function automatic result_t invert(matrix_t m);
        wide_t   e [9];
        wide_t   adj [9];
        wide_t   det;
        result_t r;
        elem_t   v [9];
        e = '{wide_t'(m.a11), wide_t'(m.a12), wide_t'(m.a13),
              wide_t'(m.a21), wide_t'(m.a22), wide_t'(m.a23),
              wide_t'(m.a31), wide_t'(m.a32), wide_t'(m.a33)};
        // adjugate in row order: transposed cofactors
        adj[0] = e[4] * e[8] - e[5] * e[7];
        adj[1] = e[2] * e[7] - e[1] * e[8];
        adj[2] = e[1] * e[5] - e[2] * e[4];
        adj[3] = e[5] * e[6] - e[3] * e[8];
        adj[4] = e[0] * e[8] - e[2] * e[6];
        adj[5] = e[2] * e[3] - e[0] * e[5];
        adj[6] = e[3] * e[7] - e[4] * e[6];
        adj[7] = e[1] * e[6] - e[0] * e[7];
        adj[8] = e[0] * e[4] - e[1] * e[3];
        det = e[0] * adj[0] + e[3] * adj[1] + e[6] * adj[2];
        r = '0;
        if (det == 0)
        begin
            r.singular = 1'b1;
            return r;
        end
        for (int i = 0; i < 9; i++)
            v[i] = divide_sat(adj[i], det);
        r.r11 = v[0]; r.r12 = v[1]; r.r13 = v[2];
        r.r21 = v[3]; r.r22 = v[4]; r.r23 = v[5];
        r.r31 = v[6]; r.r32 = v[7]; r.r33 = v[8];
        return r;
    endfunction

    task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            // retire first, then queue the matrix taken at the same edge
            if (done)
            begin
                if (inverse_q.size() == 0)
                begin
                    $error("result with no matrix outstanding");
                    fail_count++;
                end
                else
                begin
                    want = inverse_q.pop_front();
                    compare_field("r11", want.r11, result.r11);
                    compare_field("r12", want.r12, result.r12);
                    compare_field("r13", want.r13, result.r13);
                    compare_field("r21", want.r21, result.r21);
                    compare_field("r22", want.r22, result.r22);
                    compare_field("r23", want.r23, result.r23);
                    compare_field("r31", want.r31, result.r31);
                    compare_field("r32", want.r32, result.r32);
                    compare_field("r33", want.r33, result.r33);
                    compare_field("singular", 32'(want.singular), 32'(result.singular));
                end
            end
            if (start && !busy)
                inverse_q.push_back(invert(matrix));
            pending = inverse_q.size();
        end
    end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Streams directed and random 3x3 Q16.16 matrices into the inverse pipeline
// in bursts; the checker predicts and compares every inverse.
// ----------------------------------------------------------------------------
module tb import m3i_pkg::*;;

    localparam int RANDOM_ITEMS = 1330;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    matrix_t matrix;
    logic    done;
    result_t result;
    int      fail_count;
    int      pending;

    matrix_t directed_q[$];

    matrix3_inverse dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .matrix (matrix),
        .done   (done),
        .result (result)
    );

    matrix3_inverse_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .matrix     (matrix),
        .done       (done),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Pick an element: mostly moderate Q16.16 values, sometimes extremes
    // or fully random bit patterns so every bit toggles.
    function automatic elem_t pick_elem();
        case ($urandom_range(0, 9))
            0:       return SAT_MAX;
            1:       return SAT_MIN;
            2:       return elem_t'($urandom());
            3:       return elem_t'($urandom_range(0, 4)) <<< 16;
            4:       return -(elem_t'($urandom_range(1, 4)) <<< 16);
            5:       return elem_t'($urandom_range(0, 3));
            default: return elem_t'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
        endcase
    endfunction

    function automatic matrix_t random_matrix();
        matrix_t m;
        int      kind;
        m = {pick_elem(), pick_elem(), pick_elem(), pick_elem(), pick_elem(),
             pick_elem(), pick_elem(), pick_elem(), pick_elem()};
        kind = $urandom_range(0, 9);
        // force singular matrices now and then: repeated row or zero column
        if (kind == 0)
        begin
            m.a31 = m.a11; m.a32 = m.a12; m.a33 = m.a13;
        end
        else if (kind == 1)
        begin
            m.a12 = '0; m.a22 = '0; m.a32 = '0;
        end
        return m;
    endfunction

    function automatic matrix_t diag(elem_t d1, elem_t d2, elem_t d3);
        matrix_t m;
        m = '0;
        m.a11 = d1; m.a22 = d2; m.a33 = d3;
        return m;
    endfunction

    initial
    begin
        int sent;
        int burst;
        start  <= 1'b0;
        matrix <= '0;
        rst_n  = 1'b0;

        // identity, scaled, tiny (saturating), extremes, singular cases
        directed_q.push_back(diag(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000));
        directed_q.push_back(diag(32'sh0002_0000, -32'sh0004_0000, 32'sh0000_8000));
        directed_q.push_back(diag(32'sh0000_0001, 32'sh0000_0001, 32'sh0000_0001));
        directed_q.push_back(diag(SAT_MAX, SAT_MAX, SAT_MAX));
        directed_q.push_back(diag(SAT_MIN, SAT_MIN, SAT_MIN));
        directed_q.push_back(diag(SAT_MIN, 32'sh0000_0001, -32'sh0000_0001));
        directed_q.push_back('0);
        directed_q.push_back('1);
        directed_q.push_back({9{SAT_MAX}});
        directed_q.push_back({SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN, SAT_MAX,
                              SAT_MIN, SAT_MAX, SAT_MIN, SAT_MIN});
        directed_q.push_back({32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
                              32'sh0000_0000, 32'sh0001_0000, 32'sh0004_0000,
                              32'sh0005_0000, 32'sh0006_0000, 32'sh0000_0000});
        directed_q.push_back({32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
                              32'sh0004_0000, 32'sh0005_0000, 32'sh0006_0000,
                              32'sh0007_0000, 32'sh0008_0000, 32'sh0009_0000});
        directed_q.push_back({32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F,
                              32'hF0F0_F0F0, 32'h3333_3333, 32'hCCCC_CCCC,
                              32'h0000_FFFF, 32'hFFFF_0000, 32'h7FFF_0001});

        repeat (10) @(posedge clk);
        rst_n = 1'b1;

        // drive each item at the edge; hold start high through a burst
        sent = 0;
        while (sent < directed_q.size() + RANDOM_ITEMS)
        begin
            burst = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
            while (burst > 0 && sent < directed_q.size() + RANDOM_ITEMS)
            begin
                start  <= 1'b1;
                matrix <= (sent < directed_q.size()) ? directed_q[sent] : random_matrix();
                @(posedge clk);
                while (busy)
                    @(posedge clk);
                sent++;
                burst--;
            end
            if ($urandom_range(0, 2) != 0)
            begin
                start  <= 1'b0;
                matrix <= random_matrix();
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        start <= 1'b0;

        // wait for the pipe to drain, then a margin past its latency
        while (pending != 0)
            @(posedge clk);
        repeat (TOTAL_LAT + 10) @(posedge clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
